// ===== src/mkvl_pkg.sv =====
// ============================================================================
// mkvl_pkg
// Shared types, codes and helper functions of the block lacing parser.
// ============================================================================
package mkvl_pkg;

   // Default values of the top-level parameters.
   localparam int MAX_FRAMES_DEF = 256;
   localparam int TRACKS_DEF     = 4;
   localparam int SIZE_BITS_DEF  = 28;

   // Fixed field widths.
   localparam int FIELD_SIZE_W = 28;
   localparam int PTS_W        = 48;
   localparam int DUR_W        = 32;
   localparam int NUM_DUR      = 4;
   localparam int VACC_W       = 56;
   localparam int CSR_IDX_W    = 3;
   localparam int HDR_MAX      = 4095;

   // Request kinds.
   localparam logic [1:0] KIND_BEGIN = 2'd0;
   localparam logic [1:0] KIND_BYTE  = 2'd1;
   localparam logic [1:0] KIND_FETCH = 2'd2;

   // Response status codes.
   localparam logic [2:0] ST_BYTE  = 3'd0;
   localparam logic [2:0] ST_HDR   = 3'd1;
   localparam logic [2:0] ST_FRAME = 3'd2;
   localparam logic [2:0] ST_TRACK = 3'd3;
   localparam logic [2:0] ST_SIZE  = 3'd4;
   localparam logic [2:0] ST_NONE  = 3'd5;

   // Parse phases.
   localparam logic [3:0] PH_IDLE    = 4'd0;
   localparam logic [3:0] PH_TRACK   = 4'd1;
   localparam logic [3:0] PH_TIME_HI = 4'd2;
   localparam logic [3:0] PH_TIME_LO = 4'd3;
   localparam logic [3:0] PH_FLAGS   = 4'd4;
   localparam logic [3:0] PH_COUNT   = 4'd5;
   localparam logic [3:0] PH_XIPH    = 4'd6;
   localparam logic [3:0] PH_EBML    = 4'd7;
   localparam logic [3:0] PH_READY   = 4'd8;
   localparam logic [3:0] PH_ERROR   = 4'd9;

   // Lacing modes, from bits 2:1 of the flags byte.
   localparam logic [1:0] LACE_NONE  = 2'd0;
   localparam logic [1:0] LACE_XIPH  = 2'd1;
   localparam logic [1:0] LACE_FIXED = 2'd2;
   localparam logic [1:0] LACE_EBML  = 2'd3;

   localparam logic [7:0] XIPH_CONT = 8'd255;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_TRACK_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DUR_ONE     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DUR_TWO     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DUR_THREE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DUR_FOUR    = 3'd4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic exec;
      logic finish;
      logic div_take;
      logic out_load;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_div;
      logic need_finish;
      logic div_busy;
   } dp_stat_type;

   // Length of an EBML variable-size integer from its first byte.
   function automatic logic [3:0] vint_len(input logic [7:0] b);
      logic [3:0] len;
      len = 4'd8;
      for (int i = 1; i < 8; i++) begin
         if (b[i]) len = 4'(8 - i);
      end
      return len;
   endfunction

   // Bias of a signed EBML lace delta of the given length.
   function automatic logic [VACC_W-1:0] vint_bias(input logic [3:0] len);
      logic [VACC_W-1:0] r;
      r = (VACC_W'(1) << (7 * int'(len) - 1)) - VACC_W'(1);
      return r;
   endfunction

endpackage

// ===== src/mkvl_ram.sv =====
// ============================================================================
// mkvl_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ============================================================================
module mkvl_ram #(
   parameter int WIDTH = 28,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== src/mkvl_div.sv =====
// ============================================================================
// mkvl_div
// Restoring divider that produces one quotient bit per cycle.
// ============================================================================
module mkvl_div #(
   parameter int DVD_W = 28,
   parameter int DVS_W = 9
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             busy,
   output logic [DVD_W-1:0] quotient
);
   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVS_W:0]   trial;

   always_comb begin
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      trial  = {rem_ff, quo_ff[DVD_W-1]};
      if (start) begin
         cnt_in = CNT_W'(DVD_W);
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - CNT_W'(1);
         // The partial remainder stays below the divisor when the divisor is nonzero.
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = DVS_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DVS_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = (cnt_ff != '0);
   assign quotient = quo_ff;
endmodule

// ===== src/mkvl_dpath.sv =====
// ============================================================================
// mkvl_dpath
// Parser datapath: header state, frame size table, divider and result register.
// ============================================================================
module mkvl_dpath #(
   parameter int MAX_FRAMES = mkvl_pkg::MAX_FRAMES_DEF,
   parameter int TRACKS     = mkvl_pkg::TRACKS_DEF,
   parameter int SIZE_BITS  = mkvl_pkg::SIZE_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  mkvl_pkg::dp_cmd_type                   cmd,
   output mkvl_pkg::dp_stat_type                  stat,
   input  logic                                   csr_wen,
   input  logic [mkvl_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [mkvl_pkg::DUR_W-1:0]             csr_wdata,
   input  logic [1:0]                             req_kind,
   input  logic [7:0]                             req_data_byte,
   input  logic [mkvl_pkg::FIELD_SIZE_W-1:0]      req_block_bytes,
   input  logic [mkvl_pkg::PTS_W-1:0]             req_cluster_time,
   output logic [2:0]                             rsp_status,
   output logic [2:0]                             rsp_frame_track,
   output logic [mkvl_pkg::PTS_W-1:0]             rsp_frame_pts,
   output logic [mkvl_pkg::FIELD_SIZE_W-1:0]      rsp_frame_size,
   output logic [mkvl_pkg::FIELD_SIZE_W-1:0]      rsp_frame_offset,
   output logic [2:0]                             rsp_frame_flags,
   output logic                                   rsp_frame_last
);
   import mkvl_pkg::*;

   localparam int LW  = (SIZE_BITS < FIELD_SIZE_W) ? SIZE_BITS : FIELD_SIZE_W;
   localparam int AW  = $clog2(MAX_FRAMES);
   localparam int FCW = $clog2(MAX_FRAMES + 1);
   localparam int STW = LW + 9;
   localparam int EW  = VACC_W + 2;

   // Configuration registers.
   logic [2:0]       track_count_ff;
   logic [DUR_W-1:0] dur_ff [NUM_DUR];

   // Captured request.
   logic [1:0]       kind_ff;
   logic [7:0]       byte_ff;
   logic [LW-1:0]    bbytes_ff;
   logic [PTS_W-1:0] ctime_ff;

   // Parser state.
   logic [3:0]        phase_ff, phase_in;
   logic [2:0]        track_ff, track_in;
   logic [2:0]        vleft_ff, vleft_in;
   logic [3:0]        vlen_ff, vlen_in;
   logic [VACC_W-1:0] vacc_ff, vacc_in;
   logic [15:0]       rel_ff, rel_in;
   logic [7:0]        flags_ff, flags_in;
   logic [7:0]        lcount_ff, lcount_in;
   logic [7:0]        lidx_ff, lidx_in;
   logic [LW-1:0]     run_ff, run_in;
   logic [STW-1:0]    stot_ff, stot_in;
   logic [11:0]       hlen_ff, hlen_in;
   logic [LW-1:0]     blen_ff, blen_in;
   logic [PTS_W-1:0]  base_ff, base_in;
   logic [FCW-1:0]    fcount_ff, fcount_in;
   logic [FCW-1:0]    fidx_ff, fidx_in;
   logic [PTS_W-1:0]  npts_ff, npts_in;
   logic [LW-1:0]     noff_ff, noff_in;

   // Result register.
   logic [2:0]              st_ff, o_st;
   logic [2:0]              trk_ff, o_trk;
   logic [PTS_W-1:0]        pts_ff, o_pts;
   logic [FIELD_SIZE_W-1:0] size_ff, o_size;
   logic [FIELD_SIZE_W-1:0] off_ff, o_off;
   logic [2:0]              flg_ff, o_flg;
   logic                    last_ff, o_last;

   // Step helpers.
   logic [7:0]        b;
   logic [3:0]        vlen_new, vlen_eff;
   logic [VACC_W-1:0] vacc_step;
   logic [2:0]        vleft_step;
   logic              vdone;
   logic [12:0]       hl_inc;
   logic              hl_bad;
   logic [2:0]        known;
   logic [LW:0]       xrun;
   logic [EW-1:0]     ebml_next;
   logic              ebml_bad;
   logic [STW:0]      fsum;
   logic [PTS_W-1:0]  hd_pts;
   logic [LW-1:0]     fsize;
   logic [1:0]        dur_sel;

   // Memory and divider ports.
   logic          wr_en;
   logic          wr_go;
   logic [AW-1:0] wr_addr;
   logic [LW-1:0] wr_data;
   logic [LW-1:0] rd_data;
   logic          need_div, need_finish;
   logic          div_busy;
   logic [LW-1:0] div_dvd, quotient;

   // Only committed steps write the table.
   assign wr_go = wr_en && (cmd.exec || cmd.finish);

   mkvl_ram #(.WIDTH(LW), .DEPTH(MAX_FRAMES)) u_sizes (
      .clock   (clock),
      .wr_en   (wr_go),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (fidx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   mkvl_div #(.DVD_W(LW), .DVS_W(9)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.exec && need_div),
      .dividend (div_dvd),
      .divisor  ({1'b0, byte_ff} + 9'd1),
      .busy     (div_busy),
      .quotient (quotient)
   );

   assign b      = byte_ff;
   assign hl_inc = {1'b0, hlen_ff} + 13'd1;
   assign hl_bad = (hl_inc > 13'(HDR_MAX)) || (LW'(hl_inc) > blen_ff);
   assign known  = (track_count_ff > 3'(TRACKS)) ? 3'(TRACKS) : track_count_ff;
   assign hd_pts = base_ff + {{(PTS_W-16){rel_ff[15]}}, rel_ff};
   assign div_dvd = blen_ff - LW'(hl_inc);
   assign xrun   = {1'b0, run_ff} + (LW+1)'(b);
   assign fsum   = (STW+1)'(stot_ff) + (STW+1)'(hlen_ff);
   assign fsize  = (flags_ff[2:1] == LACE_FIXED) ? run_ff : rd_data;
   assign dur_sel = 2'(track_ff - 3'd1);

   // Variable-size integer decoding of one byte.
   always_comb begin
      vlen_new = vint_len(b);
      if (vleft_ff == 3'd0) begin
         vacc_step  = VACC_W'(b & (8'hFF >> vlen_new));
         vleft_step = 3'(vlen_new - 4'd1);
         vlen_eff   = vlen_new;
      end else begin
         vacc_step  = {vacc_ff[VACC_W-9:0], b};
         vleft_step = vleft_ff - 3'd1;
         vlen_eff   = vlen_ff;
      end
      vdone = (vleft_step == 3'd0);
      if (lidx_ff == 8'd0) begin
         ebml_next = EW'(vacc_step);
      end else begin
         ebml_next = EW'(run_ff) + EW'(vacc_step) - EW'(vint_bias(vlen_eff));
      end
      ebml_bad = ebml_next[EW-1] || (ebml_next > EW'(blen_ff));
   end

   always_comb begin
      phase_in  = phase_ff;
      track_in  = track_ff;
      vleft_in  = vleft_ff;
      vlen_in   = vlen_ff;
      vacc_in   = vacc_ff;
      rel_in    = rel_ff;
      flags_in  = flags_ff;
      lcount_in = lcount_ff;
      lidx_in   = lidx_ff;
      run_in    = run_ff;
      stot_in   = stot_ff;
      hlen_in   = hlen_ff;
      blen_in   = blen_ff;
      base_in   = base_ff;
      fcount_in = fcount_ff;
      fidx_in   = fidx_ff;
      npts_in   = npts_ff;
      noff_in   = noff_ff;
      o_st      = ST_NONE;
      o_trk     = '0;
      o_pts     = '0;
      o_size    = '0;
      o_off     = '0;
      o_flg     = '0;
      o_last    = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = lidx_ff[AW-1:0];
      wr_data   = xrun[LW-1:0];
      need_div    = 1'b0;
      need_finish = 1'b0;

      if (cmd.finish) begin
         if (fsum > (STW+1)'(blen_ff)) begin
            phase_in = PH_ERROR;
            o_st     = ST_SIZE;
         end else begin
            wr_en     = 1'b1;
            wr_addr   = lcount_ff[AW-1:0];
            wr_data   = LW'(blen_ff - LW'(hlen_ff) - LW'(stot_ff));
            fcount_in = FCW'({1'b0, lcount_ff} + 9'd1);
            fidx_in   = '0;
            npts_in   = hd_pts;
            noff_in   = LW'(hlen_ff);
            phase_in  = PH_READY;
            o_st      = ST_HDR;
         end
      end else if (cmd.div_take) begin
         run_in = quotient;
         o_st   = ST_HDR;
      end else begin
         unique case (kind_ff)
            KIND_BEGIN: begin
               blen_in   = bbytes_ff;
               base_in   = ctime_ff;
               hlen_in   = '0;
               vleft_in  = '0;
               lcount_in = '0;
               lidx_in   = '0;
               run_in    = '0;
               stot_in   = '0;
               fcount_in = '0;
               fidx_in   = '0;
               phase_in  = PH_TRACK;
               o_st      = ST_BYTE;
            end
            KIND_BYTE: begin
               if (phase_ff >= PH_TRACK && phase_ff <= PH_EBML) begin
                  hlen_in = hl_inc[11:0];
                  o_st    = ST_BYTE;
                  if (hl_bad) begin
                     phase_in = PH_ERROR;
                     o_st     = ST_SIZE;
                  end else begin
                     unique case (phase_ff)
                        PH_TRACK: begin
                           vacc_in  = vacc_step;
                           vleft_in = vleft_step;
                           vlen_in  = vlen_eff;
                           if (vdone) begin
                              if (vacc_step == '0 || vacc_step > VACC_W'(known)) begin
                                 phase_in = PH_ERROR;
                                 o_st     = ST_TRACK;
                              end else begin
                                 track_in = vacc_step[2:0];
                                 phase_in = PH_TIME_HI;
                              end
                           end
                        end
                        PH_TIME_HI: begin
                           rel_in   = {b, 8'h00};
                           phase_in = PH_TIME_LO;
                        end
                        PH_TIME_LO: begin
                           rel_in   = {rel_ff[15:8], b};
                           phase_in = PH_FLAGS;
                        end
                        PH_FLAGS: begin
                           flags_in = b;
                           if (b[2:1] == LACE_NONE) begin
                              lcount_in = '0;
                              wr_en     = 1'b1;
                              wr_addr   = '0;
                              wr_data   = div_dvd;
                              fcount_in = FCW'(1);
                              fidx_in   = '0;
                              npts_in   = hd_pts;
                              noff_in   = LW'(hl_inc);
                              phase_in  = PH_READY;
                              o_st      = ST_HDR;
                           end else begin
                              phase_in = PH_COUNT;
                           end
                        end
                        PH_COUNT: begin
                           lcount_in = b;
                           lidx_in   = '0;
                           run_in    = '0;
                           stot_in   = '0;
                           vleft_in  = '0;
                           if (({1'b0, b} + 9'd1) > 9'(MAX_FRAMES)) begin
                              phase_in = PH_ERROR;
                              o_st     = ST_SIZE;
                           end else if (flags_ff[2:1] == LACE_FIXED) begin
                              // Frame size arrives from the divider.
                              need_div  = 1'b1;
                              fcount_in = FCW'({1'b0, b} + 9'd1);
                              fidx_in   = '0;
                              npts_in   = hd_pts;
                              noff_in   = LW'(hl_inc);
                              phase_in  = PH_READY;
                           end else if (b == 8'd0) begin
                              need_finish = 1'b1;
                           end else if (flags_ff[2:1] == LACE_XIPH) begin
                              phase_in = PH_XIPH;
                           end else begin
                              phase_in = PH_EBML;
                           end
                        end
                        PH_XIPH: begin
                           if (xrun > (LW+1)'(blen_ff)) begin
                              phase_in = PH_ERROR;
                              o_st     = ST_SIZE;
                           end else if (b != XIPH_CONT) begin
                              wr_en   = 1'b1;
                              stot_in = stot_ff + STW'(xrun);
                              run_in  = '0;
                              lidx_in = lidx_ff + 8'd1;
                              if ((lidx_ff + 8'd1) >= lcount_ff) need_finish = 1'b1;
                           end else begin
                              run_in = xrun[LW-1:0];
                           end
                        end
                        default: begin
                           vacc_in  = vacc_step;
                           vleft_in = vleft_step;
                           vlen_in  = vlen_eff;
                           if (vdone) begin
                              if (ebml_bad) begin
                                 phase_in = PH_ERROR;
                                 o_st     = ST_SIZE;
                              end else begin
                                 run_in  = ebml_next[LW-1:0];
                                 wr_en   = 1'b1;
                                 wr_data = ebml_next[LW-1:0];
                                 stot_in = stot_ff + STW'(ebml_next[LW-1:0]);
                                 lidx_in = lidx_ff + 8'd1;
                                 if ((lidx_ff + 8'd1) >= lcount_ff) need_finish = 1'b1;
                              end
                           end
                        end
                     endcase
                  end
               end
            end
            KIND_FETCH: begin
               if (phase_ff == PH_READY && fidx_ff < fcount_ff) begin
                  o_st   = ST_FRAME;
                  o_trk  = track_ff;
                  o_pts  = npts_ff;
                  o_size = FIELD_SIZE_W'(fsize);
                  o_off  = FIELD_SIZE_W'(noff_ff);
                  if (fidx_ff == '0) begin
                     o_flg = {flags_ff[0], flags_ff[3], flags_ff[7]};
                  end
                  o_last  = ((fidx_ff + FCW'(1)) == fcount_ff);
                  npts_in = npts_ff + PTS_W'(dur_ff[dur_sel]);
                  noff_in = noff_ff + fsize;
                  fidx_in = fidx_ff + FCW'(1);
                  if ((fidx_ff + FCW'(1)) >= fcount_ff) phase_in = PH_IDLE;
               end
            end
            default: o_st = ST_NONE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         track_count_ff <= 3'd1;
         for (int i = 0; i < NUM_DUR; i++) dur_ff[i] <= '0;
         phase_ff  <= PH_IDLE;
         track_ff  <= '0;
         vleft_ff  <= '0;
         vlen_ff   <= '0;
         vacc_ff   <= '0;
         rel_ff    <= '0;
         flags_ff  <= '0;
         lcount_ff <= '0;
         lidx_ff   <= '0;
         run_ff    <= '0;
         stot_ff   <= '0;
         hlen_ff   <= '0;
         blen_ff   <= '0;
         base_ff   <= '0;
         fcount_ff <= '0;
         fidx_ff   <= '0;
         npts_ff   <= '0;
         noff_ff   <= '0;
      end else begin
         if (csr_wen) begin
            unique case (csr_index)
               CSR_TRACK_COUNT: track_count_ff <= csr_wdata[2:0];
               CSR_DUR_ONE:     dur_ff[0] <= csr_wdata;
               CSR_DUR_TWO:     dur_ff[1] <= csr_wdata;
               CSR_DUR_THREE:   dur_ff[2] <= csr_wdata;
               CSR_DUR_FOUR:    dur_ff[3] <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.exec || cmd.finish || cmd.div_take) begin
            phase_ff  <= phase_in;
            track_ff  <= track_in;
            vleft_ff  <= vleft_in;
            vlen_ff   <= vlen_in;
            vacc_ff   <= vacc_in;
            rel_ff    <= rel_in;
            flags_ff  <= flags_in;
            lcount_ff <= lcount_in;
            lidx_ff   <= lidx_in;
            run_ff    <= run_in;
            stot_ff   <= stot_in;
            hlen_ff   <= hlen_in;
            blen_ff   <= blen_in;
            base_ff   <= base_in;
            fcount_ff <= fcount_in;
            fidx_ff   <= fidx_in;
            npts_ff   <= npts_in;
            noff_ff   <= noff_in;
         end
      end
      if (cmd.load) begin
         kind_ff   <= req_kind;
         byte_ff   <= req_data_byte;
         bbytes_ff <= req_block_bytes[LW-1:0];
         ctime_ff  <= req_cluster_time;
      end
      if (cmd.out_load) begin
         st_ff   <= o_st;
         trk_ff  <= o_trk;
         pts_ff  <= o_pts;
         size_ff <= o_size;
         off_ff  <= o_off;
         flg_ff  <= o_flg;
         last_ff <= o_last;
      end
   end

   assign stat.need_div    = need_div;
   assign stat.need_finish = need_finish;
   assign stat.div_busy    = div_busy;

   assign rsp_status       = st_ff;
   assign rsp_frame_track  = trk_ff;
   assign rsp_frame_pts    = pts_ff;
   assign rsp_frame_size   = size_ff;
   assign rsp_frame_offset = off_ff;
   assign rsp_frame_flags  = flg_ff;
   assign rsp_frame_last   = last_ff;
endmodule

// ===== src/mkvl_ctrl.sv =====
// ============================================================================
// mkvl_ctrl
// Sequencing controller: request capture, evaluation, finish and divide waits.
// ============================================================================
module mkvl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  mkvl_pkg::dp_stat_type stat,
   output mkvl_pkg::dp_cmd_type  cmd
);
   import mkvl_pkg::*;

   localparam logic [1:0] C_IDLE   = 2'd0;
   localparam logic [1:0] C_EXEC   = 2'd1;
   localparam logic [1:0] C_FINISH = 2'd2;
   localparam logic [1:0] C_DIV    = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rv_ff, rv_in;
   logic       out_free;

   assign out_free = !rv_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      rv_in    = rv_ff && !rsp_tready;
      cmd      = '0;
      unique case (state_ff)
         C_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = C_EXEC;
            end
         end
         C_EXEC: begin
            if (out_free) begin
               cmd.exec = 1'b1;
               if (stat.need_div) begin
                  state_in = C_DIV;
               end else if (stat.need_finish) begin
                  state_in = C_FINISH;
               end else begin
                  cmd.out_load = 1'b1;
                  rv_in        = 1'b1;
                  state_in     = C_IDLE;
               end
            end
         end
         C_FINISH: begin
            if (out_free) begin
               cmd.finish   = 1'b1;
               cmd.out_load = 1'b1;
               rv_in        = 1'b1;
               state_in     = C_IDLE;
            end
         end
         C_DIV: begin
            if (!stat.div_busy && out_free) begin
               cmd.div_take = 1'b1;
               cmd.out_load = 1'b1;
               rv_in        = 1'b1;
               state_in     = C_IDLE;
            end
         end
         default: state_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
      end
   end

   assign req_tready = (state_ff == C_IDLE);
   assign rsp_tvalid = rv_ff;
endmodule

// ===== src/mkv_block_lacing_parser.sv =====
// ============================================================================
// mkv_block_lacing_parser
// Matroska SimpleBlock header and lacing parser with frame descriptor fetch.
// ============================================================================
//
//   channel   direction  contents
//   req_*     in         tuser: kind; tdata: data_byte, block_bytes, cluster_time
//   rsp_*     out        tuser: status; tdata: frame fields; tlast: frame_last
//   csr_*     in         write enable, register index, write data
//
// A request is registered when it is accepted and is evaluated in C_EXEC
// once the output register is free. The byte that completes a Xiph or
// EBML lace list, and a zero lace count, go on to C_FINISH to write the
// last frame size. The lace count byte of a fixed-size lace starts the
// divider; C_DIV waits until the divider is no longer busy and then takes
// the quotient as the frame size.
// Reset is synchronous; the frame size memory needs no clearing pass.
// A response waits in the output register while the next request is
// accepted; its evaluation then waits until the register is free.
//
module mkv_block_lacing_parser #(
   parameter int MAX_FRAMES = mkvl_pkg::MAX_FRAMES_DEF,
   parameter int TRACKS     = mkvl_pkg::TRACKS_DEF,
   parameter int SIZE_BITS  = mkvl_pkg::SIZE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // data_byte [7:0], block_bytes [35:8], cluster_time [83:36]
   input  logic [87:0]                       req_tdata,
   // kind [1:0]
   input  logic [1:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // frame_track [2:0], frame_pts [50:3], frame_size [78:51],
   // frame_offset [106:79], frame_flags [109:107]
   output logic [111:0]                      rsp_tdata,
   // status [2:0]
   output logic [2:0]                        rsp_tuser,
   output logic                              rsp_tlast,
   input  logic                              csr_wen,
   input  logic [mkvl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mkvl_pkg::DUR_W-1:0]        csr_wdata
);
   import mkvl_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   logic [2:0]              f_track;
   logic [PTS_W-1:0]        f_pts;
   logic [FIELD_SIZE_W-1:0] f_size;
   logic [FIELD_SIZE_W-1:0] f_offset;
   logic [2:0]              f_flags;

   // The controller owns the handshakes; the datapath owns every value.
   mkvl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   mkvl_dpath #(
      .MAX_FRAMES (MAX_FRAMES),
      .TRACKS     (TRACKS),
      .SIZE_BITS  (SIZE_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .csr_wen          (csr_wen),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_kind         (req_tuser),
      .req_data_byte    (req_tdata[7:0]),
      .req_block_bytes  (req_tdata[35:8]),
      .req_cluster_time (req_tdata[83:36]),
      .rsp_status       (rsp_tuser),
      .rsp_frame_track  (f_track),
      .rsp_frame_pts    (f_pts),
      .rsp_frame_size   (f_size),
      .rsp_frame_offset (f_offset),
      .rsp_frame_flags  (f_flags),
      .rsp_frame_last   (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, f_flags, f_offset, f_size, f_pts, f_track};
endmodule

// ===== src/mkvl_checker.sv =====
// ============================================================================
// mkvl_checker
// Port-level checks of the lacing parser, bound to its top level.
// ============================================================================
module mkvl_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [111:0] rsp_tdata,
   input logic [2:0]   rsp_tuser,
   input logic         rsp_tlast
);
   import mkvl_pkg::*;

   // After a request is accepted, req_tready drops until it has been evaluated.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted back to back");

   // Only frame descriptors carry field values.
   a_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != ST_FRAME) |-> (rsp_tdata == '0 && !rsp_tlast))
      else $error("fields set on a non-frame response");

   // A stalled response holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("stalled response changed");

   // No response is pending right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");
endmodule

bind mkv_block_lacing_parser mkvl_checker u_mkvl_checker (.*);
